// ===== design/cc20_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers of the chacha20 stream cipher
// no dependencies; compile first

package cc20_pkg;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COUNTER = 3'd6;

	// "expand 32-byte k"
	localparam logic [31:0] SIGMA [4] = '{
		32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
	};

	// the four add-xor-rotate steps of a quarter round
	typedef enum logic [1:0] {
		ST_AD16, // a += b, d ^= a, d <<<= 16
		ST_CB12, // c += d, b ^= c, b <<<= 12
		ST_AD8,  // a += b, d ^= a, d <<<= 8
		ST_CB7   // c += d, b ^= c, b <<<= 7
	} step_t;

	// key and nonce as held in the configuration registers
	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0]      nonce_low;
		logic [31:0]      nonce_high;
	} cc20_keycfg_t;

	// block generator control and status
	typedef struct packed {
		logic start;
	} cc20_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cc20_stat_t;

	// fixed rotate for each step
	function automatic logic [31:0] rol_step(input step_t step, input logic [31:0] v);
		logic [31:0] r;
		unique case (step)
			ST_AD16: r = {v[15:0], v[31:16]};
			ST_CB12: r = {v[19:0], v[31:20]};
			ST_AD8:  r = {v[23:0], v[31:24]};
			ST_CB7:  r = {v[24:0], v[31:25]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

// ===== design/cc20_ifs.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces of the chacha20 stream cipher
// no dependencies

interface cc20_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source (output valid, in_byte, last_byte, input ready);
	modport sink (input valid, in_byte, last_byte, output ready);
endinterface

interface cc20_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;

	modport source (output valid, out_byte, input ready);
	modport sink (input valid, out_byte, output ready);
endinterface

// ===== design/chacha20_stream_cipher.sv =====
`timescale 1ns / 1ps
// chacha20 stream cipher, one byte per transfer: byte xor keystream
// with the block held, an input byte goes via the emit state to the output register;
// the first byte of each block waits in the start and wait states for the generator;
// a new byte is accepted only once the last is emitted; emitting waits on result.ready
// the generator runs one add-xor-rotate step per cycle through a single shared unit
// reset clears configuration and position state, keystream words stay undefined until made

module chacha20_stream_cipher #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	cc20_item_if.sink                         item,
	cc20_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [cc20_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [cc20_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cc20_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_EMIT
	} top_state_t;

	top_state_t   state_q;
	cc20_keycfg_t keycfg_q;
	logic [31:0]  initial_counter_q;
	logic [31:0]  block_counter_q;
	logic [5:0]   pos_q;
	logic         block_ready_q;
	logic         msg_start_q;
	logic [7:0]   byte_q;
	logic         last_q;
	logic         out_valid_q;
	logic [7:0]   out_byte_q;

	cc20_ctrl_t   ctrl;
	cc20_stat_t   stat;
	logic [31:0]  rd_word;
	logic [7:0]   ks_byte;
	logic         item_xfer;
	logic         emit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keycfg_q          <= '0;
			initial_counter_q <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KEY_PART_0:      keycfg_q.key[0]    <= cfg_data;
				REG_KEY_PART_1:      keycfg_q.key[1]    <= cfg_data;
				REG_KEY_PART_2:      keycfg_q.key[2]    <= cfg_data;
				REG_KEY_PART_3:      keycfg_q.key[3]    <= cfg_data;
				REG_NONCE_LOW:       keycfg_q.nonce_low <= cfg_data;
				REG_NONCE_HIGH:      keycfg_q.nonce_high <= cfg_data[31:0];
				REG_INITIAL_COUNTER: initial_counter_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// block generator
	assign ctrl.start = (state_q == S_START);

	cc20_core #(
		.DOUBLE_ROUNDS (DOUBLE_ROUNDS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.stat    (stat),
		.keycfg  (keycfg_q),
		.counter (block_counter_q),
		.rd_idx  (pos_q[5:2]),
		.rd_word (rd_word)
	);

	// keystream byte at the current position, lowest byte of a word first
	assign ks_byte = rd_word[{pos_q[1:0], 3'b000} +: 8];

	assign item.ready = (state_q == S_IDLE);
	assign item_xfer  = item.valid && item.ready;

	// output register can take a new byte
	assign emit = (state_q == S_EMIT) && (!out_valid_q || result.ready);

	// byte sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			block_counter_q <= 32'd0;
			pos_q           <= 6'd0;
			block_ready_q   <= 1'b0;
			msg_start_q     <= 1'b1;
			byte_q          <= 8'd0;
			last_q          <= 1'b0;
			out_valid_q     <= 1'b0;
			out_byte_q      <= 8'd0;
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (out_valid_q && result.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item_xfer) begin
						byte_q <= item.in_byte;
						last_q <= item.last_byte;
						if (block_ready_q) begin
							state_q <= S_EMIT;
						end else begin
							// first block of a message starts at the configured counter
							if (msg_start_q) begin
								block_counter_q <= initial_counter_q;
								msg_start_q     <= 1'b0;
							end
							state_q <= S_START;
						end
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (stat.done) begin
						block_ready_q <= 1'b1;
						state_q       <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						out_byte_q <= byte_q ^ ks_byte;
						if (last_q) begin
							pos_q         <= 6'd0;
							block_ready_q <= 1'b0;
							msg_start_q   <= 1'b1;
						end else begin
							pos_q <= pos_q + 6'd1;
							if (&pos_q) begin
								block_counter_q <= block_counter_q + 32'd1;
								block_ready_q   <= 1'b0;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_byte = out_byte_q;

	// generator is only started when it is free
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !stat.busy)
		else $error("block generator started while busy");

	// a byte is only combined with a finished block
	a_emit_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> block_ready_q)
		else $error("byte combined without a keystream block");

	// completion only arrives while the sequencer waits for it
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == S_WAIT))
		else $error("block completion outside the wait state");

	// a transfer with a held block goes straight to the output stage
	a_fast_path: assert property (@(posedge clk) disable iff (!arst_n)
		(item_xfer && block_ready_q) |=> (state_q == S_EMIT))
		else $error("held block did not lead to output");

endmodule

// ===== design/cc20_qr_unit.sv =====
`timescale 1ns / 1ps
// shared quarter-round step: one 32-bit add, xor and fixed rotate
// depends on cc20_pkg

module cc20_qr_unit (
	input  cc20_pkg::step_t step,
	input  logic [31:0]     x,
	input  logic [31:0]     y,
	input  logic [31:0]     z,
	output logic [31:0]     sum,
	output logic [31:0]     mix
);
	import cc20_pkg::*;

	// x + y, then mix it into z and rotate
	assign sum = x + y;
	assign mix = rol_step(step, z ^ sum);

endmodule

// ===== design/cc20_core.sv =====
`timescale 1ns / 1ps
// keystream block generator: 16-word state driven through one step unit
// depends on cc20_pkg and cc20_qr_unit

module cc20_core #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cc20_pkg::cc20_ctrl_t ctrl,
	output cc20_pkg::cc20_stat_t stat,
	input  cc20_pkg::cc20_keycfg_t keycfg,
	input  logic [31:0]          counter,
	input  logic [3:0]           rd_idx,
	output logic [31:0]          rd_word
);
	import cc20_pkg::*;

	localparam int DR_W = $clog2(DOUBLE_ROUNDS);

	typedef enum logic [2:0] {
		C_IDLE,
		C_ROUND,
		C_DIAG,
		C_UNDIAG,
		C_FEED
	} core_state_t;

	core_state_t      state_q;
	step_t            step_q;
	logic [1:0]       col_q;
	logic             half_q;
	logic [DR_W-1:0]  dr_q;
	logic [3:0]       ff_q;
	logic             done_q;

	// state words, row-major 4x4; column 0 is the working column
	logic [31:0] w_q  [16];
	logic [31:0] w_nx [16];
	logic [31:0] w_upd [16];
	logic [31:0] init_w [16];

	logic        even_step;
	logic [31:0] op_x, op_y, op_z, u_sum, u_mix;

	// input block from constants, key, counter and nonce
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i]         = SIGMA[i];
			init_w[4 + 2 * i] = keycfg.key[i][31:0];
			init_w[5 + 2 * i] = keycfg.key[i][63:32];
		end
		init_w[12] = counter;
		init_w[13] = keycfg.nonce_low[31:0];
		init_w[14] = keycfg.nonce_low[63:32];
		init_w[15] = keycfg.nonce_high;
	end

	// operand selection for the shared unit
	assign even_step = (step_q == ST_AD16) || (step_q == ST_AD8);

	always_comb begin
		if (state_q == C_FEED) begin
			op_x = w_q[0];
			op_y = init_w[ff_q];
		end else if (even_step) begin
			op_x = w_q[0];
			op_y = w_q[4];
		end else begin
			op_x = w_q[8];
			op_y = w_q[12];
		end
		op_z = even_step ? w_q[12] : w_q[4];
	end

	cc20_qr_unit u_qr (
		.step (step_q),
		.x    (op_x),
		.y    (op_y),
		.z    (op_z),
		.sum  (u_sum),
		.mix  (u_mix)
	);

	// next state words
	always_comb begin
		w_upd = w_q;
		if (even_step) begin
			w_upd[0]  = u_sum;
			w_upd[12] = u_mix;
		end else begin
			w_upd[8] = u_sum;
			w_upd[4] = u_mix;
		end
		w_nx = w_q;
		unique case (state_q)
			C_IDLE: begin
				if (ctrl.start) w_nx = init_w;
			end
			C_ROUND: begin
				// after the last step, move the next column into place
				if (step_q == ST_CB7) begin
					for (int r = 0; r < 4; r++)
						for (int c = 0; c < 4; c++)
							w_nx[4 * r + c] = w_upd[4 * r + ((c + 1) % 4)];
				end else begin
					w_nx = w_upd;
				end
			end
			C_DIAG: begin
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++)
						w_nx[4 * r + c] = w_q[4 * r + ((c + r) % 4)];
			end
			C_UNDIAG: begin
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++)
						w_nx[4 * r + ((c + r) % 4)] = w_q[4 * r + c];
			end
			C_FEED: begin
				// feed-forward add around a 16-word ring
				for (int i = 0; i < 15; i++)
					w_nx[i] = w_q[i + 1];
				w_nx[15] = u_sum;
			end
			default: w_nx = w_q;
		endcase
	end

	always_ff @(posedge clk) begin
		w_q <= w_nx;
	end

	// round sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= ST_AD16;
			col_q   <= 2'd0;
			half_q  <= 1'b0;
			dr_q    <= '0;
			ff_q    <= 4'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == C_FEED) && (ff_q == 4'hf);
			unique case (state_q)
				C_IDLE: begin
					if (ctrl.start) begin
						state_q <= C_ROUND;
						step_q  <= ST_AD16;
						col_q   <= 2'd0;
						half_q  <= 1'b0;
						dr_q    <= '0;
					end
				end
				C_ROUND: begin
					unique case (step_q)
						ST_AD16: step_q <= ST_CB12;
						ST_CB12: step_q <= ST_AD8;
						ST_AD8:  step_q <= ST_CB7;
						ST_CB7:  step_q <= ST_AD16;
						default: step_q <= ST_AD16;
					endcase
					if (step_q == ST_CB7) begin
						col_q <= col_q + 2'd1;
						if (col_q == 2'd3) state_q <= half_q ? C_UNDIAG : C_DIAG;
					end
				end
				C_DIAG: begin
					half_q  <= 1'b1;
					state_q <= C_ROUND;
				end
				C_UNDIAG: begin
					half_q <= 1'b0;
					if (dr_q == DR_W'(DOUBLE_ROUNDS - 1)) begin
						ff_q    <= 4'd0;
						state_q <= C_FEED;
					end else begin
						dr_q    <= dr_q + 1'b1;
						state_q <= C_ROUND;
					end
				end
				C_FEED: begin
					ff_q <= ff_q + 4'd1;
					if (ff_q == 4'hf) state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != C_IDLE);
	assign stat.done = done_q;

	// keystream word read
	assign rd_word = w_q[rd_idx];

endmodule
